FILE: hw/rtl/ivfd_pkg.sv
package ivfd_pkg;

  localparam int unsigned CapWidth      = 27;
  localparam int unsigned FileHdrBytes  = 32;
  localparam int unsigned FrameHdrBytes = 12;
  localparam int unsigned CntWidth      = 5;

  localparam logic [CapWidth-1:0] CapReset = 27'h400_0000;

  localparam logic [CntWidth-1:0] FileHdrLast  = 5'(FileHdrBytes - 1);
  localparam logic [CntWidth-1:0] FrameHdrLast = 5'(FrameHdrBytes - 1);

  // file signature bytes
  localparam logic [7:0] SigByte0 = 8'h44;
  localparam logic [7:0] SigByte1 = 8'h4B;
  localparam logic [7:0] SigByte2 = 8'h49;
  localparam logic [7:0] SigByte3 = 8'h46;

  typedef enum logic [1:0] {
    PH_FILE    = 2'd0,
    PH_FRAME   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_BAD_SIG  = 2'd1,
    KIND_BAD_SIZE = 2'd2
  } kind_t;

  // one parser result toward the output register
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
  } res_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = SigByte0;
      2'd1:    b = SigByte1;
      2'd2:    b = SigByte2;
      default: b = SigByte3;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/ivfd_in_if.sv
interface ivfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

FILE: hw/rtl/ivfd_out_if.sv
interface ivfd_out_if;
  logic              valid;
  logic              ready;
  ivfd_pkg::kind_t   kind;
  logic [7:0]        payload_byte;
  logic              first_of_frame;
  logic              last_of_frame;

  modport source (output valid, output kind, output payload_byte, output first_of_frame,
                  output last_of_frame, input ready);
  modport sink (input valid, input kind, input payload_byte, input first_of_frame,
                input last_of_frame, output ready);
endinterface

FILE: hw/rtl/ivfd_parser.sv
module ivfd_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [7:0]                    data_byte,
  input  logic [ivfd_pkg::CapWidth-1:0] max_frame_bytes,
  output ivfd_pkg::res_t                res
);
  import ivfd_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [CntWidth-1:0]   cnt_r, cnt_nxt;
  logic [31:0]           size_r, size_nxt;
  logic [CapWidth-1:0]   remain_r, remain_nxt;
  logic                  sig_ok_r, sig_ok_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FILE;
      cnt_r    <= '0;
      size_r   <= '0;
      remain_r <= '0;
      sig_ok_r <= 1'b1;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      size_r   <= size_nxt;
      remain_r <= remain_nxt;
      sig_ok_r <= sig_ok_nxt;
    end
  end

  // one byte step: next state and result
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    size_nxt   = size_r;
    remain_nxt = remain_r;
    sig_ok_nxt = sig_ok_r;
    res        = '0;
    res.kind   = KIND_PAYLOAD;
    case (phase_r)
      PH_FILE: begin
        if (cnt_r[4:2] == 3'd0 && data_byte != sig_byte(cnt_r[1:0])) begin
          sig_ok_nxt = 1'b0;
        end
        if (cnt_r == FileHdrLast) begin
          cnt_nxt = '0;
          if (!sig_ok_nxt) begin
            phase_nxt = PH_ERROR;
            res.valid = 1'b1;
            res.kind  = KIND_BAD_SIG;
          end else begin
            phase_nxt = PH_FRAME;
            size_nxt  = '0;
          end
        end else begin
          cnt_nxt = cnt_r + CntWidth'(1);
        end
      end
      PH_FRAME: begin
        // little-endian size in the first four header bytes
        if (cnt_r[4:2] == 3'd0) begin
          case (cnt_r[1:0])
            2'd0:    size_nxt[7:0]   = size_r[7:0] | data_byte;
            2'd1:    size_nxt[15:8]  = size_r[15:8] | data_byte;
            2'd2:    size_nxt[23:16] = size_r[23:16] | data_byte;
            default: size_nxt[31:24] = size_r[31:24] | data_byte;
          endcase
        end
        if (cnt_r == FrameHdrLast) begin
          cnt_nxt = '0;
          if (size_r == 32'd0 || size_r > {5'd0, max_frame_bytes}) begin
            phase_nxt = PH_ERROR;
            res.valid = 1'b1;
            res.kind  = KIND_BAD_SIZE;
          end else begin
            remain_nxt = size_r[CapWidth-1:0];
            phase_nxt  = PH_PAYLOAD;
          end
        end else begin
          cnt_nxt = cnt_r + CntWidth'(1);
        end
      end
      PH_PAYLOAD: begin
        res.valid          = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = data_byte;
        res.first_of_frame = (remain_r == size_r[CapWidth-1:0]);
        res.last_of_frame  = (remain_r <= 27'd1);
        if (res.last_of_frame) begin
          remain_nxt = '0;
          size_nxt   = '0;
          cnt_nxt    = '0;
          phase_nxt  = PH_FRAME;
        end else begin
          remain_nxt = remain_r - CapWidth'(1);
        end
      end
      default: begin
        // sticky error: bytes are swallowed
      end
    endcase
  end

  // checks
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |-> !res.valid)
    else $error("result produced in error phase");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.valid && res.kind != KIND_PAYLOAD |=> phase_r == PH_ERROR)
    else $error("error result without entering error phase");

  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind == KIND_PAYLOAD |-> phase_r == PH_PAYLOAD)
    else $error("payload result outside payload phase");

  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remain_r != '0)
    else $error("payload phase with nothing remaining");

endmodule

FILE: hw/rtl/ivf_stream_deframer_top.sv
// ivf stream deframer
// in_ch carries the raw IVF stream, one byte per item. the 32-byte file
// header is checked for the DKIF signature, each 12-byte frame header gives
// a little-endian payload size, and out_ch carries one item per payload byte
// with first_of_frame / last_of_frame marks. a bad signature (reported on
// the last file header byte) or a frame size of zero or above the cap
// (reported on the last frame header byte) gives one error item, after
// which every further byte is swallowed until reset.
// cfg_we / cfg_data write the frame size cap; write it only while idle.
// path: an accepted byte is held in the input register, stepped through the
// parser, and its item is registered in the result register, which out_ch
// offers. throughput: one byte per cycle while out_ch is not stalled;
// header bytes produce no output item but still take a parser step each.
// reset (synchronous, rst_n low) returns to the file header, sets the cap
// to 64 MiB and empties both registers. while out_ch is stalled the result
// register holds; one more byte may sit in the input register, then
// in_ch.ready drops until out_ch drains.
module ivf_stream_deframer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  ivfd_in_if.sink                       in_ch,
  ivfd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [ivfd_pkg::CapWidth-1:0] cfg_data
);
  import ivfd_pkg::*;

  logic [CapWidth-1:0] cap_r;
  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic                out_valid_r;
  res_t                out_r;
  res_t                res;
  logic                s1_adv;
  logic                step_en;

  // frame size cap register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CapReset;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  // handshake
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign step_en     = s1_valid_r && s1_adv;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
    end
  end

  ivfd_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (step_en),
    .data_byte       (s1_byte_r),
    .max_frame_bytes (cap_r),
    .res             (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= step_en && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.payload_byte   = out_r.payload_byte;
  assign out_ch.first_of_frame = out_r.first_of_frame;
  assign out_ch.last_of_frame  = out_r.last_of_frame;

  // checks
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register dropped a stalled item");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r)
    else $error("result register dropped a stalled item");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ivfd_pkg::*;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 6;
  localparam logic [31:0] SigWord = {SigByte3, SigByte2, SigByte1, SigByte0};
  localparam logic [CapWidth-1:0] CapMax = {CapWidth{1'b1}};

  // how the closing frame header breaks the size rule
  typedef enum int unsigned {
    SIZE_ZERO         = 0,
    SIZE_CAP_PLUS_ONE = 1,
    CAP_ZERO          = 2,
    SIZE_HUGE         = 3
  } size_fault_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
  } deframed_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CapWidth-1:0] cfg_data = '0;

  ivfd_in_if  in_ch ();
  ivfd_out_if out_ch ();

  ivf_stream_deframer_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  logic [7:0]  stream_bytes [$];
  deframed_t   expected_items [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fault_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned stall_cycles = 0;

  // deframer state mirrored by the predictor
  phase_t              frm_phase;
  logic [4:0]          hdr_count;
  logic [31:0]         size_acc;
  logic [CapWidth-1:0] bytes_left;
  logic                sig_good;
  logic [CapWidth-1:0] frame_cap;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic reset_deframer();
    frm_phase  = PH_FILE;
    hdr_count  = '0;
    size_acc   = '0;
    bytes_left = '0;
    sig_good   = 1'b1;
    frame_cap  = CapReset;
  endtask

  // advance the mirrored parser by one byte, queue the item it produces
  task automatic deframe_byte(input logic [7:0] b);
    deframed_t r;
    logic      emit;
    r = '{kind: KIND_PAYLOAD, payload_byte: 8'h00, first_of_frame: 1'b0, last_of_frame: 1'b0};
    emit = 1'b0;
    case (frm_phase)
      PH_FILE: begin
        if (hdr_count < 5'd4 && b != SigWord[8*hdr_count +: 8]) sig_good = 1'b0;
        if (hdr_count == FileHdrLast) begin
          hdr_count = '0;
          if (!sig_good) begin
            frm_phase = PH_ERROR;
            r.kind = KIND_BAD_SIG;
            emit = 1'b1;
          end else begin
            frm_phase = PH_FRAME;
            size_acc = '0;
          end
        end else begin
          hdr_count = hdr_count + 5'd1;
        end
      end
      PH_FRAME: begin
        if (hdr_count < 5'd4) size_acc = size_acc | (32'(b) << (8 * hdr_count));
        if (hdr_count == FrameHdrLast) begin
          hdr_count = '0;
          if (size_acc == 32'd0 || size_acc > 32'(frame_cap)) begin
            frm_phase = PH_ERROR;
            r.kind = KIND_BAD_SIZE;
            emit = 1'b1;
          end else begin
            bytes_left = size_acc[CapWidth-1:0];
            frm_phase = PH_PAYLOAD;
          end
        end else begin
          hdr_count = hdr_count + 5'd1;
        end
      end
      PH_PAYLOAD: begin
        r.payload_byte = b;
        r.first_of_frame = (32'(bytes_left) == size_acc);
        r.last_of_frame = (bytes_left <= 1);
        emit = 1'b1;
        if (r.last_of_frame) begin
          bytes_left = '0;
          size_acc = '0;
          hdr_count = '0;
          frm_phase = PH_FRAME;
        end else begin
          bytes_left = bytes_left - 1'b1;
        end
      end
      default: ;
    endcase
    if (emit) expected_items = {expected_items, r};
  endtask

  // sender: next byte once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= 8'h00;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (stream_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= stream_bytes.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // check results first, then predict from the byte taken at this edge
  always @(posedge clk) begin
    deframed_t got;
    deframed_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{kind: out_ch.kind, payload_byte: out_ch.payload_byte,
                first_of_frame: out_ch.first_of_frame, last_of_frame: out_ch.last_of_frame};
        if (expected_items.size() == 0) begin
          $display("%0t: unexpected item kind %0d byte %02h first %b last %b", $time,
                   got.kind, got.payload_byte, got.first_of_frame, got.last_of_frame);
          fault_count++;
        end else begin
          want = expected_items.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected kind %0d byte %02h first %b last %b, got kind %0d byte %02h first %b last %b",
                     $time, want.kind, want.payload_byte, want.first_of_frame,
                     want.last_of_frame, got.kind, got.payload_byte, got.first_of_frame,
                     got.last_of_frame);
            fault_count++;
          end
          results_checked++;
          if (want.last_of_frame) frames_closed++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.data_byte);
        bytes_sent++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    stream_bytes = {stream_bytes, b};
  endtask

  task automatic push_payload(input int unsigned count);
    repeat (count) queue_byte(8'($urandom_range(255, 0)));
  endtask

  task automatic push_file_header();
    for (int i = 0; i < FileHdrBytes; i++) begin
      if (i < 4) queue_byte(SigWord[8*i +: 8]);
      else if (i == 4) queue_byte(8'h00);
      else if (i == 5) queue_byte(8'hFF);
      else queue_byte(8'($urandom_range(255, 0)));
    end
  endtask

  // little-endian size, then a random timestamp
  task automatic push_frame_header(input logic [31:0] size);
    for (int i = 0; i < 4; i++) queue_byte(size[8*i +: 8]);
    push_payload(FrameHdrBytes - 4);
  endtask

  task automatic push_random_frames(input int unsigned min_items, input int unsigned max_size);
    int unsigned pushed;
    int unsigned size;
    pushed = 0;
    while (pushed < min_items) begin
      size = $urandom_range(max_size, 1);
      push_frame_header(size);
      push_payload(size);
      pushed += FrameHdrBytes + size;
    end
  endtask

  // every byte taken, every item out, then let header bytes clear the pipe
  task automatic wait_drained();
    @(negedge clk);
    while (stream_bytes.size() != 0 || in_ch.valid || expected_items.size() != 0)
      @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_cap(input logic [CapWidth-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_cap = value;
    @(negedge clk);
  endtask

  initial begin
    logic [CapWidth-1:0] cap;
    logic [31:0]         bad_size;
    size_fault_t         fault;
    string               fault_text;
    reset_deframer();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sparse sender, mostly stalled receiver; reset cap, directed frames first
    send_idle_pct = 29;
    recv_idle_pct = 85;
    push_file_header();
    push_frame_header(1);
    queue_byte(8'h00);
    push_frame_header(2);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    push_frame_header(3);
    push_payload(3);
    push_random_frames(35, 24);
    wait_drained();

    // widest cap, leave a frame open across the next cap change
    write_cap(CapMax);
    push_random_frames(40, 24);
    push_frame_header(20);
    push_payload(7);
    wait_drained();

    // roles swapped; cap of one must not cut the open frame
    send_idle_pct = 85;
    recv_idle_pct = 29;
    write_cap(1);
    push_payload(13);
    push_random_frames(30, 1);
    wait_drained();

    cap = CapWidth'($urandom_range(16, 2));
    write_cap(cap);
    push_random_frames(35, cap);
    wait_drained();

    // no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cap = CapWidth'($urandom_range(60, 17));
    write_cap(cap);
    push_random_frames(35, cap);
    wait_drained();

    // closing bad frame size, then bytes the sticky error must swallow
    fault = size_fault_t'($urandom_range(3, 0));
    cap = (fault == CAP_ZERO) ? '0 : CapWidth'($urandom_range(40, 4));
    write_cap(cap);
    if (fault != CAP_ZERO) push_random_frames(20, cap);
    case (fault)
      SIZE_ZERO: begin
        bad_size = 32'd0;
        fault_text = "zero size";
      end
      SIZE_CAP_PLUS_ONE: begin
        bad_size = 32'(cap) + 32'd1;
        fault_text = "size one above cap";
      end
      CAP_ZERO: begin
        bad_size = 32'($urandom_range(8, 1));
        fault_text = "cap of zero";
      end
      default: begin
        bad_size = $urandom | 32'h0800_0000;
        fault_text = "oversized frame";
      end
    endcase
    push_frame_header(bad_size);
    push_payload(16);
    wait_drained();

    $display("stream of %0d bytes, %0d items checked, %0d frames closed", bytes_sent,
             results_checked, frames_closed);
    $display("caps: reset, all ones, one, random small; stream closed by %s", fault_text);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
